/* hdl/line_fold_wrapper_core_assert.svh */
// Assertion macros shared by the line folding block.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef LINE_FOLD_WRAPPER_CORE_ASSERT_SVH
`define LINE_FOLD_WRAPPER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lfw_pkg.sv */
// ----------------------------------------------------------------------------
// lfw_pkg
// Shared widths, codes and helper functions of the line folding block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfw_pkg;

  localparam int unsigned BufferDepthDef = 64;
  localparam int unsigned WidthCap       = 60;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned LineWidthW     = 6;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 6;

  localparam logic [LineWidthW-1:0] LineWidthReset = 6'd60;

  localparam logic [ByteW-1:0] NewlineByte = 8'd10;
  localparam logic [ByteW-1:0] SpaceByte   = 8'd32;
  localparam logic [ByteW-1:0] TabByte     = 8'd9;
  localparam logic [ByteW-1:0] VtabByte    = 8'd11;
  localparam logic [ByteW-1:0] FeedByte    = 8'd12;
  localparam logic [ByteW-1:0] ReturnByte  = 8'd13;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineWidth     = 2'd0,
    CfgBreakAtBlanks = 2'd1
  } cfg_idx_e;

  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return (c == SpaceByte) || (c == TabByte) || (c == VtabByte) ||
           (c == FeedByte) || (c == ReturnByte);
  endfunction

endpackage

`default_nettype wire

/* hdl/lfw_in_if.sv */
// ----------------------------------------------------------------------------
// lfw_in_if
// Input byte channel: valid/ready handshake with the raw byte and its flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfw_in_if;
  import lfw_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_source;

  modport source (output valid, output data_byte, output end_of_source, input ready);
  modport sink   (input valid, input data_byte, input end_of_source, output ready);
endinterface

`default_nettype wire

/* hdl/lfw_out_if.sv */
// ----------------------------------------------------------------------------
// lfw_out_if
// Output byte channel: valid/ready handshake with the folded byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfw_out_if;
  import lfw_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/lfw_ram.sv */
// ----------------------------------------------------------------------------
// lfw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/line_fold_wrapper_core.sv */
// ----------------------------------------------------------------------------
// line_fold_wrapper_core
// Folds a byte stream so that no output line exceeds the configured width (zero acts as one).
// ----------------------------------------------------------------------------
// Usage: bytes arrive on in_i and folded bytes leave on out_o, both valid/ready
// channels; a transfer happens when valid and ready are high at a clock edge.
// Configuration (line width, blank mode) is to be written through cfg_we_i only
// while the block is idle; the block itself does not enforce this. Bytes other
// than newline are kept in a circular line buffer in a RAM; a byte that
// completes no line passes through the accept and check steps. A break or
// flush emits each byte by a RAM read and then an output load, then the
// newline; in blank mode a backward search over the buffer reads and checks
// each byte examined, at most width bytes. The single RAM read port is
// shared between search and emission. in_i.ready is high only while the
// sequencer waits for a byte. Results pass through one output register, so
// a stalled receiver holds the sequencer in its emit step and no byte is lost;
// the next input can be taken while the last result still waits.
// Reset empties the buffer and sets width 60, blank mode off; the RAM itself
// needs no clearing since only bytes below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_fold_wrapper_core_assert.svh"

module line_fold_wrapper_core #(
  parameter int unsigned BufferDepth = lfw_pkg::BufferDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lfw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfw_pkg::CfgDataW-1:0] cfg_wdata_i,
  lfw_in_if.sink                       in_i,
  lfw_out_if.source                    out_o
);

  import lfw_pkg::*;

  localparam int unsigned PtrW = $clog2(BufferDepth);
  localparam int unsigned CntW = $clog2(BufferDepth + 1);
  localparam int unsigned WCap = (WidthCap < BufferDepth - 1) ? WidthCap : BufferDepth - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e                state_q;
  logic [LineWidthW-1:0] line_width_q;
  logic                  break_at_blanks_q;
  logic [CntW-1:0]       fill_cnt_q;
  logic [PtrW-1:0]       head_q;
  logic [CntW-1:0]       len_q;
  logic [PtrW-1:0]       off_q;
  logic                  flush_q;
  logic                  eos_q;
  logic                  out_valid_q;
  logic [ByteW-1:0]      out_byte_q;
  logic                  out_last_q;

  logic [LineWidthW-1:0] lw_clip;
  logic [PtrW-1:0]       eff_w;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  ram_we;
  logic [PtrW-1:0]       ram_waddr;
  logic [PtrW-1:0]       ram_raddr;
  logic [ByteW-1:0]      ram_rdata;
  logic                  more_after_break;
  logic                  emit_act;
  logic                  emit_ld;
  logic                  emit_stall;

  function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] a,
                                              input logic [PtrW-1:0] b);
    logic [PtrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PtrW + 1)'(BufferDepth)) begin
      s = s - (PtrW + 1)'(BufferDepth);
    end
    return s[PtrW-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q      <= LineWidthReset;
      break_at_blanks_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLineWidth:     line_width_q      <= cfg_wdata_i[LineWidthW-1:0];
        CfgBreakAtBlanks: break_at_blanks_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Width zero acts as one; the width never exceeds the cap or the buffer.
  always_comb begin
    if (line_width_q == '0) begin
      lw_clip = LineWidthW'(1);
    end else if (line_width_q > LineWidthW'(WCap)) begin
      lw_clip = LineWidthW'(WCap);
    end else begin
      lw_clip = line_width_q;
    end
  end
  assign eff_w = PtrW'(lw_clip);

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign emit_ld    = (state_q == ST_EMIT_LD);
  assign emit_act   = (state_q == ST_EMIT_RD) || emit_ld;
  assign emit_stall = emit_ld && !out_free;

  // The output register takes a new byte in this cycle.
  assign out_load = out_free && (emit_ld || (state_q == ST_EMIT_RD && len_q == '0));

  assign ram_we    = accept && (in_i.data_byte != NewlineByte) &&
                     (fill_cnt_q < CntW'(BufferDepth));
  assign ram_waddr = ptr_add(head_q, PtrW'(fill_cnt_q));
  assign ram_raddr = (state_q == ST_SCAN_RD || state_q == ST_SCAN_CHK) ?
                     ptr_add(head_q, off_q - PtrW'(1)) : head_q;

  // A break on the last byte of a source is followed by a flush of the rest.
  assign more_after_break = !flush_q && eos_q && (fill_cnt_q != '0);

  lfw_ram #(
    .Width (ByteW),
    .Depth (BufferDepth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.data_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_cnt_q  <= '0;
      head_q      <= '0;
      len_q       <= '0;
      off_q       <= '0;
      flush_q     <= 1'b0;
      eos_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            eos_q <= in_i.end_of_source;
            if (in_i.data_byte == NewlineByte) begin
              flush_q <= 1'b1;
              len_q   <= fill_cnt_q;
              state_q <= ST_EMIT_RD;
            end else begin
              if (fill_cnt_q < CntW'(BufferDepth)) begin
                fill_cnt_q <= fill_cnt_q + CntW'(1);
              end
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (fill_cnt_q > CntW'(eff_w)) begin
            flush_q <= 1'b0;
            if (break_at_blanks_q) begin
              off_q   <= eff_w;
              state_q <= ST_SCAN_RD;
            end else begin
              len_q   <= CntW'(eff_w);
              state_q <= ST_EMIT_RD;
            end
          end else if (eos_q && fill_cnt_q != '0) begin
            flush_q <= 1'b1;
            len_q   <= fill_cnt_q;
            state_q <= ST_EMIT_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN_RD: begin
          state_q <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          // Search backward from the width for the last blank.
          if (is_blank(ram_rdata)) begin
            len_q   <= CntW'(off_q);
            state_q <= ST_EMIT_RD;
          end else if (off_q == PtrW'(1)) begin
            len_q   <= CntW'(eff_w);
            state_q <= ST_EMIT_RD;
          end else begin
            off_q   <= off_q - PtrW'(1);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_EMIT_RD: begin
          if (len_q == '0) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              out_byte_q  <= NewlineByte;
              out_last_q  <= !more_after_break;
              if (more_after_break) begin
                flush_q <= 1'b1;
                len_q   <= fill_cnt_q;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end else begin
            state_q <= ST_EMIT_LD;
          end
        end
        ST_EMIT_LD: begin
          // The read address stays on the head, so the data holds while stalled.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= ram_rdata;
            out_last_q  <= 1'b0;
            head_q      <= ptr_add(head_q, PtrW'(1));
            fill_cnt_q  <= fill_cnt_q - CntW'(1);
            len_q       <= len_q - CntW'(1);
            state_q     <= ST_EMIT_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;

  `LFW_ASSERT_SAME(a_fill_bound, 1'b1, fill_cnt_q <= CntW'(BufferDepth), "fill count overflow")
  `LFW_ASSERT_NEXT(a_busy_after_accept, accept, !in_i.ready, "accepted while busy")
  `LFW_ASSERT_SAME(a_len_in_fill, emit_act, len_q <= fill_cnt_q, "emit run longer than buffer")
  `LFW_ASSERT_NEXT(a_stall_holds, emit_stall, emit_ld && $stable(head_q), "stalled emit advanced")

endmodule

`default_nettype wire
